[hw/rtl/isd_pkg.sv]
// isd_pkg: shared widths, constants, codes and types of the IMU step detector.
// Used by isd_ctrl, isd_dp and imu_step_detector; depends on nothing.
package isd_pkg;

    localparam int SAMPLE_BITS     = 16;
    localparam int EXTRA_FRAC_BITS = 8;

    localparam int TIME_W    = 32;
    localparam int INTV_W    = 16;
    localparam int COEF_W    = 16;
    localparam int THR_CFG_W = 15;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 16;

    localparam int Q_SHIFT   = 16;
    localparam int MAG_W     = SAMPLE_BITS + EXTRA_FRAC_BITS;
    localparam int SUM_W     = 2 * SAMPLE_BITS;
    localparam int REM_W     = MAG_W + 2;
    localparam int ALPHA_W   = Q_SHIFT + 1;
    localparam int DIV_STEPS = ALPHA_W;
    localparam int ITER_N    = (MAG_W > DIV_STEPS) ? MAG_W : DIV_STEPS;
    localparam int CNT_W     = $clog2(ITER_N + 1);
    localparam int SQ_OPS    = 7;
    localparam int DEN_W     = TIME_W + 1;
    localparam int NUM_W     = TIME_W + Q_SHIFT + 1;

    localparam int MUL_A_W   = (MAG_W > THR_CFG_W) ? MAG_W : THR_CFG_W;
    localparam int MUL_B_W   = (SAMPLE_BITS > ALPHA_W) ? SAMPLE_BITS : ALPHA_W;
    localparam int PROD_W    = MUL_A_W + MUL_B_W;
    localparam int GTHR_W    = 2 * THR_CFG_W;
    localparam int GCMP_W    = (SUM_W > GTHR_W) ? SUM_W : GTHR_W;
    localparam int FLOOR_W   = THR_CFG_W + EXTRA_FRAC_BITS;
    localparam int THR_W     = ((MAG_W > FLOOR_W) ? MAG_W : FLOOR_W) + 1;
    localparam int BIG_W     = THR_W + 4;

    localparam logic [TIME_W-1:0]  DEFAULT_DT  = TIME_W'(20);
    localparam logic [MUL_B_W-1:0] BASE_KEEP_W = MUL_B_W'(65208);
    localparam logic [MUL_B_W-1:0] BASE_NEW_W  = MUL_B_W'(328);
    localparam logic [MUL_B_W-1:0] ONE_Q16     = MUL_B_W'(65536);
    localparam logic [PROD_W:0]    HALF_Q16    = (PROD_W + 1)'(32768);

    localparam longint unsigned OFF_RAW =
        ((64'd32768 << EXTRA_FRAC_BITS) + 64'd50) / 64'd100;
    localparam logic [THR_W-1:0] OFFSET_008G = THR_W'(OFF_RAW);

    localparam logic [INTV_W-1:0]    MIN_INTV_RST = INTV_W'(300);
    localparam logic [COEF_W-1:0]    GRAV_TAU_RST = COEF_W'(500);
    localparam logic [COEF_W-1:0]    ENV_KEEP_RST = COEF_W'(13107);
    localparam logic [THR_CFG_W-1:0] BASE_THR_RST = THR_CFG_W'(819);
    localparam logic [THR_CFG_W-1:0] GYRO_THR_RST = THR_CFG_W'(400);

    localparam logic [MAG_W-1:0] GRAV_RST = MAG_W'(4096) << EXTRA_FRAC_BITS;
    localparam logic [MAG_W-1:0] BL_RST   = MAG_W'(BASE_THR_RST) << EXTRA_FRAC_BITS;

    localparam logic [CFG_IDX_W-1:0] CFG_MIN_INTV  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRAV_TAU  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ENV_KEEP  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_THR  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_GYRO_THR  = 3'd4;

    // Multiplier operand select; the first seven follow the squaring order.
    typedef enum logic [3:0] {
        MS_AX, MS_AY, MS_AZ, MS_GX, MS_GY, MS_GZ, MS_GT,
        MS_GRAV, MS_EOLD, MS_ENEW, MS_BOLD, MS_BNEW, MS_NONE
    } t_msrc;

    typedef struct packed {
        logic [INTV_W-1:0]    min_intv;
        logic [COEF_W-1:0]    grav_tau;
        logic [COEF_W-1:0]    env_keep;
        logic [THR_CFG_W-1:0] base_thr;
        logic [THR_CFG_W-1:0] gyro_thr;
    } t_cfg;

    typedef struct packed {
        logic  capture;
        logic  mul_en;
        t_msrc mul_src;
        logic  iter_init;
        logic  root_step;
        logic  div_step;
        logic  thr_load;
        logic  decide;
        logic  out_load;
    } t_cmd;

    typedef struct packed {
        logic out_free;
    } t_sts;

    function automatic logic [SAMPLE_BITS-1:0] f_abs(input logic [SAMPLE_BITS-1:0] x);
        return x[SAMPLE_BITS-1] ? (~x + 1'b1) : x;
    endfunction

endpackage

[hw/rtl/isd_ctrl.sv]
// isd_ctrl: sequencer of the step detector; walks one sample through the datapath.
// Depends on isd_pkg.
module isd_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  isd_pkg::t_sts i_sts,
    output isd_pkg::t_cmd o_cmd
);

    typedef enum logic [12:0] {
        S_IDLE  = 13'b0000000000001,
        S_SQ    = 13'b0000000000010,
        S_SQW   = 13'b0000000000100,
        S_ITER  = 13'b0000000001000,
        S_GMUL  = 13'b0000000010000,
        S_EOLD  = 13'b0000000100000,
        S_ENEW  = 13'b0000001000000,
        S_BOLD  = 13'b0000010000000,
        S_BNEW  = 13'b0000100000000,
        S_BWAIT = 13'b0001000000000,
        S_THR   = 13'b0010000000000,
        S_DEC   = 13'b0100000000000,
        S_DONE  = 13'b1000000000000
    } t_state;

    t_state                    r_state, n_state;
    logic [isd_pkg::CNT_W-1:0] r_cnt, n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_ready = 1'b0;
        o_cmd   = '{mul_src: isd_pkg::MS_NONE, default: 1'b0};
        unique case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.capture = 1'b1;
                    n_cnt         = '0;
                    n_state       = S_SQ;
                end
            end
            S_SQ: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_src = isd_pkg::t_msrc'(r_cnt[3:0]);
                if (r_cnt == isd_pkg::CNT_W'(isd_pkg::SQ_OPS - 1)) begin
                    n_state = S_SQW;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_SQW: begin
                o_cmd.iter_init = 1'b1;
                n_cnt           = '0;
                n_state         = S_ITER;
            end
            S_ITER: begin
                o_cmd.root_step = (r_cnt < isd_pkg::CNT_W'(isd_pkg::MAG_W));
                o_cmd.div_step  = (r_cnt < isd_pkg::CNT_W'(isd_pkg::DIV_STEPS));
                if (r_cnt == isd_pkg::CNT_W'(isd_pkg::ITER_N - 1)) begin
                    n_state = S_GMUL;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_GMUL: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_src = isd_pkg::MS_GRAV;
                n_state       = S_EOLD;
            end
            S_EOLD: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_src = isd_pkg::MS_EOLD;
                n_state       = S_ENEW;
            end
            S_ENEW: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_src = isd_pkg::MS_ENEW;
                n_state       = S_BOLD;
            end
            S_BOLD: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_src = isd_pkg::MS_BOLD;
                n_state       = S_BNEW;
            end
            S_BNEW: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_src = isd_pkg::MS_BNEW;
                n_state       = S_BWAIT;
            end
            S_BWAIT: begin
                n_state = S_THR;
            end
            S_THR: begin
                o_cmd.thr_load = 1'b1;
                n_state        = S_DEC;
            end
            S_DEC: begin
                o_cmd.decide = 1'b1;
                n_state      = S_DONE;
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

[hw/rtl/isd_dp.sv]
// isd_dp: datapath of the step detector: shared multiplier, square root, divider,
// filters, step decision and output register. Depends on isd_pkg.
module isd_dp (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  isd_pkg::t_cmd                          i_cmd,
    output isd_pkg::t_sts                          o_sts,
    input  isd_pkg::t_cfg                          i_cfg,
    input  logic signed [isd_pkg::SAMPLE_BITS-1:0] i_accel_x,
    input  logic signed [isd_pkg::SAMPLE_BITS-1:0] i_accel_y,
    input  logic signed [isd_pkg::SAMPLE_BITS-1:0] i_accel_z,
    input  logic signed [isd_pkg::SAMPLE_BITS-1:0] i_gyro_x,
    input  logic signed [isd_pkg::SAMPLE_BITS-1:0] i_gyro_y,
    input  logic signed [isd_pkg::SAMPLE_BITS-1:0] i_gyro_z,
    input  logic [isd_pkg::TIME_W-1:0]             i_sample_time_ms,
    input  logic                                   i_ready,
    output logic                                   o_valid,
    output logic                                   o_step_detected,
    output logic [isd_pkg::TIME_W-1:0]             o_step_total
);

    localparam int S  = isd_pkg::SAMPLE_BITS;
    localparam int MW = isd_pkg::MAG_W;
    localparam int PW = isd_pkg::PROD_W;

    // sample capture
    logic [S-1:0]                    r_abs [6];
    logic [isd_pkg::TIME_W-1:0]      r_now, r_prev, r_last, r_dt, r_tally;
    logic                            r_prev_valid;
    logic [isd_pkg::TIME_W-1:0]      w_dt;

    // multiplier
    logic [isd_pkg::MUL_A_W-1:0]     w_ma;
    logic [isd_pkg::MUL_B_W-1:0]     w_mb;
    logic [PW-1:0]                   r_prod;
    isd_pkg::t_msrc                  r_psrc;

    // accumulators and filter state
    logic [isd_pkg::SUM_W-1:0]       r_asum, r_gsum;
    logic [isd_pkg::GTHR_W-1:0]      r_gthr;
    logic [MW-1:0]                   r_grav, r_env, r_bl;
    logic [PW-1:0]                   r_eacc, r_bacc;
    logic                            r_dneg;
    logic [MW-1:0]                   w_dabs, w_hp, w_dec;
    logic [PW:0]                     w_rnd;

    // square root
    logic [isd_pkg::SUM_W-1:0]       r_rs;
    logic [isd_pkg::REM_W-1:0]       r_rrem, w_rtry, w_rtrial;
    logic [MW-1:0]                   r_root;

    // divider
    logic [isd_pkg::DEN_W-1:0]       r_drem, r_den, w_den;
    logic [isd_pkg::ALPHA_W-1:0]     r_dnum, r_alpha;
    logic [isd_pkg::NUM_W-1:0]       w_num;
    logic [isd_pkg::DEN_W:0]         w_dtry;

    // decision
    logic [isd_pkg::THR_W-1:0]       r_thr, w_floor, w_boff;
    logic                            w_step, r_step;
    logic                            r_o_valid, r_o_step;
    logic [isd_pkg::TIME_W-1:0]      r_o_total;

    assign w_dt = (r_prev_valid && i_sample_time_ms > r_prev) ?
                  i_sample_time_ms - r_prev : isd_pkg::DEFAULT_DT;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_abs[0] <= isd_pkg::f_abs(i_accel_x);
            r_abs[1] <= isd_pkg::f_abs(i_accel_y);
            r_abs[2] <= isd_pkg::f_abs(i_accel_z);
            r_abs[3] <= isd_pkg::f_abs(i_gyro_x);
            r_abs[4] <= isd_pkg::f_abs(i_gyro_y);
            r_abs[5] <= isd_pkg::f_abs(i_gyro_z);
            r_now    <= i_sample_time_ms;
            r_dt     <= w_dt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev       <= '0;
            r_prev_valid <= 1'b0;
        end else if (i_cmd.capture) begin
            r_prev       <= i_sample_time_ms;
            r_prev_valid <= 1'b1;
        end
    end

    // gravity error and high-passed magnitude, taken from the root result
    assign w_dabs = (r_root < r_grav) ? r_grav - r_root : r_root - r_grav;
    assign w_hp   = (r_root > r_grav) ? r_root - r_grav : '0;

    always_comb begin
        w_ma = '0;
        w_mb = '0;
        unique case (i_cmd.mul_src)
            isd_pkg::MS_AX, isd_pkg::MS_AY, isd_pkg::MS_AZ,
            isd_pkg::MS_GX, isd_pkg::MS_GY, isd_pkg::MS_GZ: begin
                w_ma = isd_pkg::MUL_A_W'(r_abs[i_cmd.mul_src[2:0]]);
                w_mb = isd_pkg::MUL_B_W'(r_abs[i_cmd.mul_src[2:0]]);
            end
            isd_pkg::MS_GT: begin
                w_ma = isd_pkg::MUL_A_W'(i_cfg.gyro_thr);
                w_mb = isd_pkg::MUL_B_W'(i_cfg.gyro_thr);
            end
            isd_pkg::MS_GRAV: begin
                w_ma = isd_pkg::MUL_A_W'(w_dabs);
                w_mb = isd_pkg::MUL_B_W'(r_alpha);
            end
            isd_pkg::MS_EOLD: begin
                w_ma = isd_pkg::MUL_A_W'(r_env);
                w_mb = isd_pkg::MUL_B_W'(i_cfg.env_keep);
            end
            isd_pkg::MS_ENEW: begin
                w_ma = isd_pkg::MUL_A_W'(w_hp);
                w_mb = isd_pkg::ONE_Q16 - isd_pkg::MUL_B_W'(i_cfg.env_keep);
            end
            isd_pkg::MS_BOLD: begin
                w_ma = isd_pkg::MUL_A_W'(r_bl);
                w_mb = isd_pkg::BASE_KEEP_W;
            end
            isd_pkg::MS_BNEW: begin
                w_ma = isd_pkg::MUL_A_W'(r_env);
                w_mb = isd_pkg::BASE_NEW_W;
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= PW'(w_ma) * PW'(w_mb);
        if (i_cmd.mul_src == isd_pkg::MS_GRAV) begin
            r_dneg <= (r_root < r_grav);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_psrc <= isd_pkg::MS_NONE;
        end else begin
            r_psrc <= i_cmd.mul_en ? i_cmd.mul_src : isd_pkg::MS_NONE;
        end
    end

    // rounded Q16 product of the gravity step
    assign w_rnd = {1'b0, r_prod} + isd_pkg::HALF_Q16;
    assign w_dec = MW'(w_rnd >> isd_pkg::Q_SHIFT);

    // route each registered product to its consumer in the cycle after issue
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_asum <= '0;
            r_gsum <= '0;
        end else begin
            unique case (r_psrc)
                isd_pkg::MS_AX, isd_pkg::MS_AY, isd_pkg::MS_AZ: begin
                    r_asum <= r_asum + isd_pkg::SUM_W'(r_prod);
                end
                isd_pkg::MS_GX, isd_pkg::MS_GY, isd_pkg::MS_GZ: begin
                    r_gsum <= r_gsum + isd_pkg::SUM_W'(r_prod);
                end
                isd_pkg::MS_GT: begin
                    r_gthr <= isd_pkg::GTHR_W'(r_prod);
                end
                isd_pkg::MS_EOLD: begin
                    r_eacc <= r_prod;
                end
                isd_pkg::MS_BOLD: begin
                    r_bacc <= r_prod;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grav <= isd_pkg::GRAV_RST;
            r_env  <= '0;
            r_bl   <= isd_pkg::BL_RST;
        end else begin
            unique case (r_psrc)
                isd_pkg::MS_GRAV: begin
                    if (!r_dneg) begin
                        r_grav <= r_grav + w_dec;
                    end else begin
                        r_grav <= (w_dec >= r_grav) ? '0 : r_grav - w_dec;
                    end
                end
                isd_pkg::MS_ENEW: begin
                    r_env <= MW'(({1'b0, r_eacc} + {1'b0, r_prod} + isd_pkg::HALF_Q16)
                                 >> isd_pkg::Q_SHIFT);
                end
                isd_pkg::MS_BNEW: begin
                    r_bl <= MW'(({1'b0, r_bacc} + {1'b0, r_prod} + isd_pkg::HALF_Q16)
                                >> isd_pkg::Q_SHIFT);
                end
                default: begin
                end
            endcase
        end
    end

    // digit-by-digit square root of the accel sum, one result bit a cycle
    assign w_rtry   = {r_rrem[isd_pkg::REM_W-3:0], r_rs[isd_pkg::SUM_W-1 -: 2]};
    assign w_rtrial = {r_root, 2'b01};

    // alpha = round(dt * 2^16 / (tau + dt)), one quotient bit a cycle
    assign w_den  = isd_pkg::DEN_W'(i_cfg.grav_tau) + isd_pkg::DEN_W'(r_dt);
    assign w_num  = (isd_pkg::NUM_W'(r_dt) << isd_pkg::Q_SHIFT)
                  + isd_pkg::NUM_W'(w_den >> 1);
    assign w_dtry = {r_drem, r_dnum[isd_pkg::ALPHA_W-1]};

    always_ff @(posedge i_clk) begin
        if (i_cmd.iter_init) begin
            r_rs   <= r_asum;
            r_rrem <= '0;
            r_root <= '0;
            r_den  <= w_den;
            r_drem <= isd_pkg::DEN_W'(w_num >> isd_pkg::ALPHA_W);
            r_dnum <= w_num[isd_pkg::ALPHA_W-1:0];
        end else begin
            if (i_cmd.root_step) begin
                r_rs <= r_rs << 2;
                if (w_rtry >= w_rtrial) begin
                    r_rrem <= w_rtry - w_rtrial;
                    r_root <= {r_root[MW-2:0], 1'b1};
                end else begin
                    r_rrem <= w_rtry;
                    r_root <= {r_root[MW-2:0], 1'b0};
                end
            end
            if (i_cmd.div_step) begin
                r_dnum <= r_dnum << 1;
                if (w_dtry >= {1'b0, r_den}) begin
                    r_drem  <= isd_pkg::DEN_W'(w_dtry - {1'b0, r_den});
                    r_alpha <= {r_alpha[isd_pkg::ALPHA_W-2:0], 1'b1};
                end else begin
                    r_drem  <= isd_pkg::DEN_W'(w_dtry);
                    r_alpha <= {r_alpha[isd_pkg::ALPHA_W-2:0], 1'b0};
                end
            end
        end
    end

    // detection threshold: max(floor, baseline + 0.08 g)
    assign w_floor = isd_pkg::THR_W'(i_cfg.base_thr) << isd_pkg::EXTRA_FRAC_BITS;
    assign w_boff  = isd_pkg::THR_W'(r_bl) + isd_pkg::OFFSET_008G;

    always_ff @(posedge i_clk) begin
        if (i_cmd.thr_load) begin
            r_thr <= (w_floor > w_boff) ? w_floor : w_boff;
        end
    end

    assign w_step = (isd_pkg::THR_W'(r_env) > r_thr)
                 && ((r_now - r_last) > isd_pkg::TIME_W'(i_cfg.min_intv))
                 && ((isd_pkg::GCMP_W'(r_gsum) > isd_pkg::GCMP_W'(r_gthr))
                  || (((isd_pkg::BIG_W'(r_env) << 2) + isd_pkg::BIG_W'(r_env))
                      > (isd_pkg::BIG_W'(r_thr) << 3)));

    always_ff @(posedge i_clk) begin
        if (i_cmd.decide) begin
            r_step <= w_step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tally <= '0;
            r_last  <= '0;
        end else if (i_cmd.decide && w_step) begin
            r_tally <= r_tally + 1'b1;
            r_last  <= r_now;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_o_valid <= 1'b1;
        end else if (i_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_o_step  <= r_step;
            r_o_total <= r_tally;
        end
    end

    assign o_sts.out_free  = !r_o_valid || i_ready;
    assign o_valid         = r_o_valid;
    assign o_step_detected = r_o_step;
    assign o_step_total    = r_o_total;

endmodule

[hw/rtl/imu_step_detector.sv]
// imu_step_detector: top level of the step counter; holds the register file and
// joins the sequencer isd_ctrl to the datapath isd_dp. Depends on isd_pkg.
//
// Step counter on timestamped IMU samples. Write the five registers through
// the plain write port while the block is idle; indexes five to seven are
// ignored. Each accepted word yields exactly one result word: step_detected
// and the running step_total, which wraps at 32 bits and clears only on reset.
// One sample is worked on at a time: the input side opens again in the cycle
// after the result is handed to the output register. The time per sample is
// set by the digit-by-digit square root of the acceleration magnitude (one
// root bit a cycle, with the gravity weight divider running beside it) plus
// the single shared multiplier, which takes the seven squares and the five
// filter products in turn. A finished result waits in the output register
// while the next sample is already accepted and computed; it stalls only if
// that one is done too.
module imu_step_detector (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  logic [isd_pkg::CFG_IDX_W-1:0]          i_cfg_addr,
    input  logic [isd_pkg::CFG_W-1:0]              i_cfg_data,
    input  logic                                   i_valid,
    output logic                                   o_ready,
    input  logic signed [isd_pkg::SAMPLE_BITS-1:0] i_accel_x,
    input  logic signed [isd_pkg::SAMPLE_BITS-1:0] i_accel_y,
    input  logic signed [isd_pkg::SAMPLE_BITS-1:0] i_accel_z,
    input  logic signed [isd_pkg::SAMPLE_BITS-1:0] i_gyro_x,
    input  logic signed [isd_pkg::SAMPLE_BITS-1:0] i_gyro_y,
    input  logic signed [isd_pkg::SAMPLE_BITS-1:0] i_gyro_z,
    input  logic [isd_pkg::TIME_W-1:0]             i_sample_time_ms,
    output logic                                   o_valid,
    input  logic                                   i_ready,
    output logic                                   o_step_detected,
    output logic [isd_pkg::TIME_W-1:0]             o_step_total
);

    isd_pkg::t_cfg r_cfg;
    isd_pkg::t_cmd w_cmd;
    isd_pkg::t_sts w_sts;

    // Register file: latch a write at once; unknown indexes drop silently.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_intv <= isd_pkg::MIN_INTV_RST;
            r_cfg.grav_tau <= isd_pkg::GRAV_TAU_RST;
            r_cfg.env_keep <= isd_pkg::ENV_KEEP_RST;
            r_cfg.base_thr <= isd_pkg::BASE_THR_RST;
            r_cfg.gyro_thr <= isd_pkg::GYRO_THR_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                isd_pkg::CFG_MIN_INTV: r_cfg.min_intv <= i_cfg_data;
                isd_pkg::CFG_GRAV_TAU: r_cfg.grav_tau <= i_cfg_data;
                isd_pkg::CFG_ENV_KEEP: r_cfg.env_keep <= i_cfg_data;
                isd_pkg::CFG_BASE_THR: begin
                    r_cfg.base_thr <= i_cfg_data[isd_pkg::THR_CFG_W-1:0];
                end
                isd_pkg::CFG_GYRO_THR: begin
                    r_cfg.gyro_thr <= i_cfg_data[isd_pkg::THR_CFG_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Sequencer: accept a word when idle, then step the datapath through it.
    isd_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    // Datapath: arithmetic, filter state, step tally and output register.
    isd_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_sts            (w_sts),
        .i_cfg            (r_cfg),
        .i_accel_x        (i_accel_x),
        .i_accel_y        (i_accel_y),
        .i_accel_z        (i_accel_z),
        .i_gyro_x         (i_gyro_x),
        .i_gyro_y         (i_gyro_y),
        .i_gyro_z         (i_gyro_z),
        .i_sample_time_ms (i_sample_time_ms),
        .i_ready          (i_ready),
        .o_valid          (o_valid),
        .o_step_detected  (o_step_detected),
        .o_step_total     (o_step_total)
    );

    // An accepted word keeps the input side closed on the next cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("input accepted while a sample is in work");

    // A new result never overwrites one that is still waiting.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |-> w_sts.out_free)
        else $error("result loaded over a pending word");

    // Output valid rises only from a result load.
    a_valid_from_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(w_cmd.out_load))
        else $error("output valid without a result load");

endmodule

[tb/sv/imu_step_checker.sv]
// imu_step_checker: watches the sample and result channels of imu_step_detector,
// predicts step_detected and step_total per sample and compares. Depends on isd_pkg.
module imu_step_checker
    import isd_pkg::*;
(
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [CFG_IDX_W-1:0]          i_cfg_addr,
    input  logic [CFG_W-1:0]              i_cfg_data,
    input  logic                          i_valid,
    input  logic                          i_ready_in,
    input  logic signed [SAMPLE_BITS-1:0] i_accel_x,
    input  logic signed [SAMPLE_BITS-1:0] i_accel_y,
    input  logic signed [SAMPLE_BITS-1:0] i_accel_z,
    input  logic signed [SAMPLE_BITS-1:0] i_gyro_x,
    input  logic signed [SAMPLE_BITS-1:0] i_gyro_y,
    input  logic signed [SAMPLE_BITS-1:0] i_gyro_z,
    input  logic [TIME_W-1:0]             i_sample_time_ms,
    input  logic                          i_out_valid,
    input  logic                          i_out_ready,
    input  logic                          i_step_detected,
    input  logic [TIME_W-1:0]             i_step_total,
    output int                            o_fail_count,
    output int                            o_pending,
    output int                            o_results,
    output int                            o_steps
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic              step;
        logic [TIME_W-1:0] total;
    } t_step_word;

    t_step_word step_words_q[$];

    longint unsigned min_intv, grav_tau, env_keep, base_thr, gyro_thr;
    longint unsigned tally, last_step_at, prev_at, grav, env, baseline;
    bit              prev_seen;

    function automatic longint unsigned sq_sum(longint signed a, longint signed b,
                                               longint signed c);
        return longint'(a * a + b * b + c * c);
    endfunction

    // floor(sqrt(s * 4^EXTRA_FRAC_BITS)), one root bit per pass
    function automatic longint unsigned scaled_root(longint unsigned s);
        longint unsigned rem, root, pair, trial;
        rem = 0;
        root = 0;
        for (int i = SAMPLE_BITS + EXTRA_FRAC_BITS - 1; i >= 0; i--) begin
            pair = (i >= EXTRA_FRAC_BITS) ? (s >> (2 * (i - EXTRA_FRAC_BITS))) & 3 : 0;
            rem = (rem << 2) | pair;
            trial = (root << 2) | 1;
            root <<= 1;
            if (rem >= trial) begin
                rem -= trial;
                root |= 1;
            end
        end
        return root;
    endfunction

    function automatic t_step_word predict_step(
        longint signed ax, longint signed ay, longint signed az,
        longint signed gx, longint signed gy, longint signed gz,
        logic [TIME_W-1:0] now);
        t_step_word w;
        longint unsigned dt, mag, den, alpha, d, dec, hp, thr, flr, off;
        logic [TIME_W-1:0] since;
        bit step;
        dt = 20;
        if (prev_seen && now > prev_at) dt = now - prev_at;
        prev_at = now;
        prev_seen = 1;
        mag = scaled_root(sq_sum(ax, ay, az));
        den = grav_tau + dt;
        alpha = ((dt << 16) + den / 2) / den;
        if (mag >= grav) begin
            grav += ((mag - grav) * alpha + 32768) >> 16;
        end else begin
            d = grav - mag;
            dec = (d * alpha + 32768) >> 16;
            grav = (dec >= grav) ? 0 : grav - dec;
        end
        hp = (mag > grav) ? mag - grav : 0;
        env = (env_keep * env + (65536 - env_keep) * hp + 32768) >> 16;
        baseline = (65208 * baseline + 328 * env + 32768) >> 16;
        off = ((64'd32768 << EXTRA_FRAC_BITS) + 50) / 100;
        flr = base_thr << EXTRA_FRAC_BITS;
        thr = baseline + off;
        if (flr > thr) thr = flr;
        since = now - last_step_at[TIME_W-1:0];
        step = env > thr && since > min_intv &&
               (sq_sum(gx, gy, gz) > gyro_thr * gyro_thr || env * 5 > thr * 8);
        if (step) begin
            tally = (tally + 1) & 32'hFFFF_FFFF;
            last_step_at = now;
        end
        w.step = step;
        w.total = tally[TIME_W-1:0];
        return w;
    endfunction

    always @(posedge i_clk) begin
        t_step_word got, want;
        if (!i_rst_n) begin
            min_intv = 300; grav_tau = 500; env_keep = 13107;
            base_thr = 819; gyro_thr = 400;
            tally = 0; last_step_at = 0; prev_at = 0; prev_seen = 0;
            grav = 4096 << EXTRA_FRAC_BITS; env = 0;
            baseline = 819 << EXTRA_FRAC_BITS;
            step_words_q.delete();
            o_fail_count = 0; o_results = 0; o_steps = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_MIN_INTV: min_intv = i_cfg_data;
                    CFG_GRAV_TAU: grav_tau = i_cfg_data;
                    CFG_ENV_KEEP: env_keep = i_cfg_data;
                    CFG_BASE_THR: base_thr = i_cfg_data[THR_CFG_W-1:0];
                    CFG_GYRO_THR: gyro_thr = i_cfg_data[THR_CFG_W-1:0];
                    default: ;
                endcase
            end
            if (i_valid && i_ready_in)
                step_words_q.push_back(predict_step(i_accel_x, i_accel_y, i_accel_z,
                                                    i_gyro_x, i_gyro_y, i_gyro_z,
                                                    i_sample_time_ms));
            if (i_out_valid && i_out_ready) begin
                got.step = i_step_detected;
                got.total = i_step_total;
                o_results++;
                if (got.step) o_steps++;
                if (step_words_q.size() == 0) begin
                    $error("result word with nothing expected");
                    o_fail_count++;
                end else begin
                    want = step_words_q.pop_front();
                    if (got.step !== want.step) begin
                        $error("step_detected: expected %0d, got %0d", want.step, got.step);
                        o_fail_count++;
                    end
                    if (got.total !== want.total) begin
                        $error("step_total: expected %0d, got %0d", want.total, got.total);
                        o_fail_count++;
                    end
                end
            end
        end
        o_pending = step_words_q.size();
    end
endmodule

[tb/sv/imu_step_detector_tb.sv]
// imu_step_detector_tb: drives samples and register writes into imu_step_detector
// and gives the verdict; prediction lives in imu_step_checker. Depends on isd_pkg.
module imu_step_detector_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import isd_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;

    logic                   i_clk, i_rst_n;
    logic                   cfg_we;
    logic [CFG_IDX_W-1:0]   cfg_addr;
    logic [CFG_W-1:0]       cfg_data;
    logic                   smp_valid, smp_ready, res_valid, res_ready;
    logic signed [SAMPLE_BITS-1:0] ax, ay, az, gx, gy, gz;
    logic [TIME_W-1:0]      stamp;
    logic                   step_detected;
    logic [TIME_W-1:0]      step_total;
    int                     fail_count, pending, results, steps;
    int                     send_idle_pct, recv_stall_pct, quiet_cycles;
    logic [TIME_W-1:0]      clock_ms;

    imu_step_detector dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(cfg_we), .i_cfg_addr(cfg_addr), .i_cfg_data(cfg_data),
        .i_valid(smp_valid), .o_ready(smp_ready),
        .i_accel_x(ax), .i_accel_y(ay), .i_accel_z(az),
        .i_gyro_x(gx), .i_gyro_y(gy), .i_gyro_z(gz),
        .i_sample_time_ms(stamp),
        .o_valid(res_valid), .i_ready(res_ready),
        .o_step_detected(step_detected), .o_step_total(step_total)
    );

    imu_step_checker checker_i (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(cfg_we), .i_cfg_addr(cfg_addr), .i_cfg_data(cfg_data),
        .i_valid(smp_valid), .i_ready_in(smp_ready),
        .i_accel_x(ax), .i_accel_y(ay), .i_accel_z(az),
        .i_gyro_x(gx), .i_gyro_y(gy), .i_gyro_z(gz),
        .i_sample_time_ms(stamp),
        .i_out_valid(res_valid), .i_out_ready(res_ready),
        .i_step_detected(step_detected), .i_step_total(step_total),
        .o_fail_count(fail_count), .o_pending(pending),
        .o_results(results), .o_steps(steps)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Receiver: redraw ready at every falling edge from the current stall rate.
    always @(negedge i_clk)
        res_ready <= ($urandom_range(99) >= recv_stall_pct);

    // Watchdog: count cycles with no accepted word on either channel.
    always @(posedge i_clk) begin
        if ((smp_valid && smp_ready) || (res_valid && res_ready) || !i_rst_n)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no word moved in %0d cycles", WATCHDOG_LIMIT);
            $display("FAILURE");
            $finish;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(negedge i_clk);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= val;
        @(negedge i_clk);
        cfg_we <= 1'b0;
    endtask

    // Hold the sample until the handshake; an idle cycle or drain drops valid.
    task automatic send_sample(input logic signed [15:0] x, y, z, p, q, r,
                               input logic [TIME_W-1:0] t);
        while ($urandom_range(99) < send_idle_pct) begin
            smp_valid <= 1'b0;
            @(negedge i_clk);
        end
        ax <= x; ay <= y; az <= z; gx <= p; gy <= q; gz <= r;
        stamp <= t;
        smp_valid <= 1'b1;
        do @(posedge i_clk); while (!smp_ready);
        @(negedge i_clk);
    endtask

    // Drop valid, wait until every result has come back, then give a margin.
    task automatic drain();
        smp_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (60) @(negedge i_clk);
    endtask

    // One walking stride: gravity on z plus a bump that rises and falls, with gyro swing.
    task automatic send_stride(input int amp, input int gyro_amp, input int dt_ms);
        int bump;
        for (int k = 0; k < 8; k++) begin
            bump = (k < 4) ? amp * k / 3 : amp * (7 - k) / 3;
            clock_ms += dt_ms;
            send_sample($urandom_range(600) - 300, $urandom_range(600) - 300,
                        4096 + bump, gyro_amp, $urandom_range(400) - 200,
                        $urandom_range(400) - 200, clock_ms);
        end
    endtask

    task automatic send_noise(input int n);
        for (int k = 0; k < n; k++) begin
            // Mostly advance time; now and then repeat or step it back.
            case ($urandom_range(9))
                0: ;
                1: clock_ms -= $urandom_range(50);
                2: clock_ms += $urandom_range(70000);
                default: clock_ms += $urandom_range(40);
            endcase
            send_sample($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                        clock_ms);
        end
    endtask

    initial begin
        cfg_we = 0; cfg_addr = '0; cfg_data = '0;
        smp_valid = 0;
        ax = 0; ay = 0; az = 0; gx = 0; gy = 0; gz = 0; stamp = 0;
        send_idle_pct = 0; recv_stall_pct = 0; quiet_cycles = 0;
        clock_ms = 1000;
        i_rst_n = 1'b0;
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: first sample, field extremes, repeated and backward stamps.
        send_sample(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 0);
        send_sample(-16'sh8000, -16'sh8000, -16'sh8000, -16'sh8000, -16'sh8000,
                    -16'sh8000, 0);
        send_sample(0, 0, 0, 0, 0, 0, 32'hFFFF_FFFF);
        send_sample(0, 0, 4096, 0, 0, 0, 5);
        send_sample(-1, 1, -4096, 1, -1, 0, 32'h8000_0000);
        send_sample(16'sh5555, -16'sh2AAB, 16'sh2AAA, 16'sh5555, -16'sh2AAB, 16'sh2AAA, 90);
        clock_ms = 2000;
        send_stride(12000, 2000, 20);
        send_stride(12000, 0, 20);
        drain();

        // Zero settings and writes to unused indexes; zero tau, gravity tracks magnitude outright.
        write_reg(CFG_MIN_INTV, 0);
        write_reg(CFG_GRAV_TAU, 0);
        write_reg(CFG_ENV_KEEP, 0);
        write_reg(CFG_BASE_THR, 0);
        write_reg(CFG_GYRO_THR, 0);
        write_reg(3'd5, 16'hFFFF);
        write_reg(3'd7, 16'h1234);
        send_noise(12);
        drain();

        for (int phase = 0; phase < 8; phase++) begin
            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 61; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 61; end
                default: begin send_idle_pct = 13; recv_stall_pct = 13; end
            endcase
            case (phase)
                0: begin
                    write_reg(CFG_MIN_INTV, 16'hFFFF);
                    write_reg(CFG_GRAV_TAU, 16'hFFFF);
                    write_reg(CFG_ENV_KEEP, 16'hFFFF);
                    write_reg(CFG_BASE_THR, 16'h7FFF);
                    write_reg(CFG_GYRO_THR, 16'h7FFF);
                end
                1: begin
                    write_reg(CFG_MIN_INTV, 300);
                    write_reg(CFG_GRAV_TAU, 500);
                    write_reg(CFG_ENV_KEEP, 13107);
                    write_reg(CFG_BASE_THR, 819);
                    write_reg(CFG_GYRO_THR, 400);
                end
                default: begin
                    write_reg(CFG_MIN_INTV, $urandom_range(400));
                    write_reg(CFG_GRAV_TAU, $urandom_range(2000, 1));
                    write_reg(CFG_ENV_KEEP, $urandom_range(40000));
                    write_reg(CFG_BASE_THR, $urandom_range(1500));
                    write_reg(CFG_GYRO_THR, $urandom_range(800));
                end
            endcase
            // Mostly strides of random strength, with some raw noise between.
            for (int s = 0; s < 12; s++)
                send_stride($urandom_range(16000, 500), $urandom_range(3000),
                            $urandom_range(60, 10));
            send_noise(30);
            drain();
        end

        $display("covered %0d results, %0d counted steps, over 10 register settings",
                 results, steps);
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule
